// ===== rtl/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and codes for the bounded deque with search.
// ----------------------------------------------------------------------------
package bdq_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_CONTAINS   = 3'd6,
        OP_REMOVE_ALL = 3'd7
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN
    } state_t;

    typedef struct packed {
        op_t                op;
        logic signed [31:0] value;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic               found;
        stat_t              status;
        logic [4:0]         count;
    } result_t;

endpackage

// ===== rtl/bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_search
// Ring-buffer deque of DEPTH entries in one synchronous RAM, with search.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: a transfer happens at a rising edge with start high and
//   busy low; cmd carries the op code and the value.
//   Result channel: done is high for exactly one cycle while result holds
//   the value, found flag, status and new count. The receiver cannot stall:
//   each result is taken in the cycle it is shown.
// Flow (from the accept edge to the done pulse):
//   push, and any op that fails or finds an empty deque: done is shown in the
//   next cycle; busy stays low, so these ops sustain one transfer per cycle.
//   pop / peek: one RAM read, in state S_READ, with busy high.
//   contains / remove all: a walk in S_SCAN over n entries, n up to the count
//   (contains stops at the first hit), so at most DEPTH entries.
//   The walk is set by the single read port of the entry RAM: one entry per
//   cycle, and remove all writes kept entries back through the write port
//   in the same pass.
// Reset: the deque is empty (front and count cleared); RAM contents are not
//   cleared, since only held entries are ever read.
// ----------------------------------------------------------------------------
module bounded_deque_with_search #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  bdq_pkg::cmd_t    cmd,
    output logic             busy,
    output logic             done,
    output bdq_pkg::result_t result
);
    import bdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // entry RAM
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [WIDTH-1:0] wdata;
    logic [AW-1:0]    raddr;

    // control and datapath registers
    state_t           state_reg,  state_next;
    logic [AW-1:0]    front_reg,  front_next;
    logic [CW-1:0]    count_reg,  count_next;
    logic             done_reg,   done_next;
    op_t              op_reg,     op_next;
    logic [WIDTH-1:0] val_reg,    val_next;
    logic [AW-1:0]    idx_reg,    idx_next;
    logic [AW-1:0]    kept_reg,   kept_next;
    result_t          result_reg, result_next;

    logic [31:0]      cmd_val_u;
    logic [WIDTH-1:0] cmd_val;
    logic [CW-1:0]    count_m1;
    logic             empty;
    logic             full;
    logic             match;
    logic             last;

    // ring position of front + off, off < DEPTH
    function automatic logic [AW-1:0] ring_pos(input logic [AW-1:0] front,
                                               input logic [AW-1:0] off);
        logic [AW:0] sum;
        sum = {1'b0, front} + {1'b0, off};
        if (sum >= (AW+1)'(DEPTH))
            sum = sum - (AW+1)'(DEPTH);
        return sum[AW-1:0];
    endfunction

    assign cmd_val_u = cmd.value;
    assign cmd_val   = WIDTH'(cmd_val_u);
    assign count_m1  = count_reg - CW'(1);
    assign empty     = (count_reg == '0);
    assign full      = (count_reg >= CW'(DEPTH));
    assign match     = (rdata_reg == val_reg);
    assign last      = ((CW'(idx_reg) + CW'(1)) == count_reg);

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        kept_reg   <= kept_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        done_next   = 1'b0;
        op_next     = op_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        kept_next   = kept_reg;
        result_next = result_reg;
        we          = 1'b0;
        waddr       = front_reg;
        wdata       = val_reg;
        raddr       = front_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next               = cmd.op;
                    val_next              = cmd_val;
                    idx_next              = '0;
                    kept_next             = '0;
                    result_next.out_value = '0;
                    result_next.found     = 1'b0;
                    result_next.status    = STAT_OK;
                    result_next.count     = 5'(count_reg);
                    case (cmd.op)
                        OP_PUSH_FRONT,
                        OP_PUSH_BACK:
                        begin
                            done_next = 1'b1;
                            if (full)
                                result_next.status = STAT_FULL;
                            else
                            begin
                                we    = 1'b1;
                                wdata = cmd_val;
                                if (cmd.op == OP_PUSH_FRONT)
                                begin
                                    front_next = (front_reg == '0) ? AW'(DEPTH - 1)
                                                                   : front_reg - AW'(1);
                                    waddr      = front_next;
                                end
                                else
                                    waddr = ring_pos(front_reg, count_reg[AW-1:0]);
                                count_next        = count_reg + CW'(1);
                                result_next.count = 5'(count_next);
                            end
                        end
                        OP_REMOVE_ALL:
                        begin
                            if (empty)
                                done_next = 1'b1;
                            else
                                state_next = S_SCAN;
                        end
                        default:
                        begin
                            if (empty)
                            begin
                                done_next          = 1'b1;
                                result_next.status = STAT_EMPTY;
                            end
                            else if (cmd.op == OP_CONTAINS)
                                state_next = S_SCAN;
                            else
                            begin
                                state_next = S_READ;
                                if (cmd.op == OP_POP_BACK || cmd.op == OP_PEEK_BACK)
                                    raddr = ring_pos(front_reg, count_m1[AW-1:0]);
                            end
                        end
                    endcase
                end
            end

            S_READ:
            begin
                // pop or peek: RAM data is the addressed end entry
                state_next            = S_IDLE;
                done_next             = 1'b1;
                result_next.out_value = signed'(32'(rdata_reg));
                if (op_reg == OP_POP_FRONT)
                begin
                    front_next = ring_pos(front_reg, AW'(1));
                    count_next = count_m1;
                end
                else if (op_reg == OP_POP_BACK)
                    count_next = count_m1;
                result_next.count = 5'(count_next);
            end

            S_SCAN:
            begin
                // rdata_reg holds the entry at offset idx_reg
                if (op_reg == OP_CONTAINS)
                begin
                    if (match || last)
                    begin
                        state_next        = S_IDLE;
                        done_next         = 1'b1;
                        result_next.found = match;
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        raddr    = ring_pos(front_reg, idx_next);
                    end
                end
                else
                begin
                    // compaction: kept entries go back at offset kept_reg,
                    // which never passes the read offset
                    if (!match)
                    begin
                        we        = 1'b1;
                        waddr     = ring_pos(front_reg, kept_reg);
                        wdata     = rdata_reg;
                        kept_next = kept_reg + AW'(1);
                    end
                    if (last)
                    begin
                        state_next        = S_IDLE;
                        done_next         = 1'b1;
                        count_next        = CW'(kept_reg) + CW'(!match);
                        result_next.count = 5'(count_next);
                    end
                    else
                    begin
                        idx_next = idx_reg + AW'(1);
                        raddr    = ring_pos(front_reg, idx_next);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== tb/tb_bounded_deque_with_search.sv =====
// ----------------------------------------------------------------------------
// tb_bounded_deque_with_search
// Self-checking bench for the bounded deque: a scoreboard class keeps its
// own ring, predicts every result from each accepted command, and compares
// the results field by field. The stimulus is a directed pass (empty, full
// and extreme values), then randomized phases that fill and drain the deque.
// ----------------------------------------------------------------------------
module tb_bounded_deque_with_search;

    timeunit 1ns;
    timeprecision 1ps;

    import bdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int WIDTH        = 32;
    localparam int RANDOM_ITEMS = 800;
    // Longest legal quiet stretch is a long sender gap plus a full scan;
    // this is many times that.
    localparam int QUIET_LIMIT  = 2000;
    localparam int TAIL_CYCLES  = DEPTH + 4;

    // ------------------------------------------------------------------------
    // Scoreboard: private copy of the ring, predicted results in order.
    // ------------------------------------------------------------------------
    class deque_scoreboard #(int CAP = 16);
        logic [31:0] slots [CAP];
        int          head;
        int          fill;
        result_t     expected_results [$];
        int          errors;
        int          checked;
        int          full_rejects;
        int          empty_errors;
        int          search_hits;
        int          full_reached;

        function new();
            foreach (slots[i]) slots[i] = '0;
            head = 0;
            fill = 0;
            errors = 0;
            checked = 0;
            full_rejects = 0;
            empty_errors = 0;
            search_hits = 0;
            full_reached = 0;
        endfunction

        // Advance the private ring by one command and return its result.
        function result_t deque_step(cmd_t c);
            result_t     r;
            logic [31:0] v;
            logic [31:0] e;
            int          kept;

            r = '0;
            r.status = STAT_OK;
            v = c.value;
            case (c.op)
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (fill >= CAP)
                    begin
                        r.status = STAT_FULL;
                        full_rejects++;
                    end
                    else
                    begin
                        if (c.op == OP_PUSH_FRONT)
                        begin
                            head = (head + CAP - 1) % CAP;
                            slots[head] = v;
                        end
                        else
                            slots[(head + fill) % CAP] = v;
                        fill++;
                        if (fill == CAP) full_reached++;
                    end
                end
                OP_REMOVE_ALL:
                begin
                    // Compact survivors toward the front, order kept.
                    kept = 0;
                    for (int i = 0; i < fill; i++)
                    begin
                        e = slots[(head + i) % CAP];
                        if (e != v)
                        begin
                            slots[(head + kept) % CAP] = e;
                            kept++;
                        end
                    end
                    fill = kept;
                end
                default:
                begin
                    if (fill == 0)
                    begin
                        r.status = STAT_EMPTY;
                        empty_errors++;
                    end
                    else
                    begin
                        case (c.op)
                            OP_POP_FRONT, OP_PEEK_FRONT:
                            begin
                                r.out_value = slots[head];
                                if (c.op == OP_POP_FRONT)
                                begin
                                    head = (head + 1) % CAP;
                                    fill--;
                                end
                            end
                            OP_POP_BACK, OP_PEEK_BACK:
                            begin
                                r.out_value = slots[(head + fill - 1) % CAP];
                                if (c.op == OP_POP_BACK) fill--;
                            end
                            default:
                            begin
                                for (int i = 0; i < fill; i++)
                                    if (slots[(head + i) % CAP] == v) r.found = 1'b1;
                                if (r.found) search_hits++;
                            end
                        endcase
                    end
                end
            endcase
            r.count = fill[4:0];
            return r;
        endfunction

        function void note_cmd(cmd_t c);
            expected_results.push_back(deque_step(c));
        endfunction

        function void check_result(result_t got);
            result_t want;

            if (expected_results.size() == 0)
            begin
                $error("result with no command pending: %h", got);
                errors++;
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (got.out_value !== want.out_value)
            begin
                $error("out_value: expected %h, actual %h", want.out_value, got.out_value);
                errors++;
            end
            if (got.found !== want.found)
            begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("count: expected %0d, actual %0d", want.count, got.count);
                errors++;
            end
        endfunction
    endclass

    logic    clk;
    logic    rst_n;
    logic    start;
    cmd_t    cmd;
    logic    busy;
    logic    done;
    result_t result;

    deque_scoreboard #(DEPTH) sb;
    int quiet_cycles = 0;

    bounded_deque_with_search #(
        .DEPTH (DEPTH),
        .WIDTH (WIDTH)
    ) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor. Inputs change only at rising edges and outputs only after
    // them, so the falling edge sees exactly what the next rising edge will
    // take: no race with the design's own updates.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (done) sb.check_result(result);
            if (start && !busy) sb.note_cmd(cmd);
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: too long without any transfer in either direction.
    initial
    begin
        @(posedge rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
        $display("*** FAILED ***");
        $finish;
    end

    // Sender gap: mostly back to back, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Small pool so searches and removes hit, plus extremes and raw words.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return 32'($urandom_range(0, 7));
        if (r == 6) return 32'h7FFF_FFFF;
        if (r == 7) return 32'h8000_0000;
        return $urandom;
    endfunction

    // One command transfer, then an optional idle gap. Called at a rising
    // edge; start stays high when the next command follows at once, so it
    // never gets two assignments in one step.
    task automatic send_op(input op_t o, input logic [31:0] v, input int gap);
        cmd_t c;
        bit   taken;

        c.op = o;
        c.value = v;
        start <= 1'b1;
        cmd <= c;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Hold off until every predicted result has come back.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (sb.expected_results.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int   mode;
        bit   burst;
        int   r;
        int   push_pct;
        int   pop_pct;
        op_t  o;

        start <= 1'b0;
        cmd   <= '0;
        rst_n <= 1'b0;
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: every read-type op on an empty deque ---
        send_op(OP_POP_FRONT,  32'h0, pick_gap());
        send_op(OP_POP_BACK,   32'h0, pick_gap());
        send_op(OP_PEEK_FRONT, 32'h0, pick_gap());
        send_op(OP_PEEK_BACK,  32'h0, pick_gap());
        send_op(OP_CONTAINS,   32'h0, pick_gap());
        send_op(OP_REMOVE_ALL, 32'h0, pick_gap());   // empty remove is a success

        // Extremes at both ends: [-1, max, min, 0]
        send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF, pick_gap());
        send_op(OP_PUSH_BACK,  32'h8000_0000, pick_gap());
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF, pick_gap());
        send_op(OP_PUSH_BACK,  32'h0000_0000, pick_gap());
        send_op(OP_PEEK_FRONT, 32'h0, pick_gap());
        send_op(OP_PEEK_BACK,  32'h0, pick_gap());
        send_op(OP_CONTAINS,   32'h8000_0000, pick_gap());
        send_op(OP_CONTAINS,   32'h0001_2345, pick_gap());  // miss, full walk
        send_op(OP_POP_FRONT,  32'h0, pick_gap());
        send_op(OP_POP_BACK,   32'h0, pick_gap());
        send_op(OP_REMOVE_ALL, 32'h7FFF_FFFF, pick_gap());  // leaves [min]

        // Fill to the bound with duplicates, then push at both ends when full.
        for (int i = 0; i < DEPTH - 1; i++)
            send_op(i[0] ? OP_PUSH_FRONT : OP_PUSH_BACK,
                    i[0] ? 32'h0000_0003 : 32'h55AA_55AA, 0);
        send_op(OP_PUSH_FRONT, 32'h1, pick_gap());
        send_op(OP_PUSH_BACK,  32'h2, pick_gap());
        send_op(OP_CONTAINS,   32'h8000_0000, pick_gap());
        send_op(OP_REMOVE_ALL, 32'h0000_0003, pick_gap());  // compacts a full ring
        send_op(OP_REMOVE_ALL, 32'h55AA_55AA, pick_gap());
        send_op(OP_REMOVE_ALL, 32'h8000_0000, pick_gap());  // back to empty

        // --- random: phases biased to fill, to drain, or balanced ---
        mode = 2;
        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 40 == 0)
            begin
                mode  = $urandom_range(0, 2);
                burst = ($urandom_range(0, 3) == 0);   // stretch with no idling
            end
            if (n % 200 == 199) drain();

            case (mode)
                0:       begin push_pct = 60; pop_pct = 10; end
                1:       begin push_pct = 15; pop_pct = 50; end
                default: begin push_pct = 35; pop_pct = 25; end
            endcase
            r = $urandom_range(0, 99);
            if (r < push_pct)
                o = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            else if (r < push_pct + pop_pct)
                o = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
            else if (r < push_pct + pop_pct + 10)
                o = $urandom_range(0, 1) ? OP_PEEK_BACK : OP_PEEK_FRONT;
            else if (r < push_pct + pop_pct + 18)
                o = OP_REMOVE_ALL;
            else
                o = OP_CONTAINS;
            send_op(o, pick_value(), burst ? 0 : pick_gap());
        end

        // --- wind down: all results in, then a quiet tail for strays ---
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Checked %0d results; deque reached full %0d times.",
                 sb.checked, sb.full_reached);
        $display("Rejected pushes %0d, empty errors %0d, search hits %0d.",
                 sb.full_rejects, sb.empty_errors, sb.search_hits);
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/bdq_pkg.sv
rtl/bounded_deque_with_search.sv
tb/tb_bounded_deque_with_search.sv
